FILE: rtl/tds_pkg.sv
// Shared types and constants for the task dependency scheduler.
// Used by tds_out_reg and task_dependency_scheduler; depends on nothing.
package tds_pkg;

  localparam int MAX_TASKS      = 64;
  localparam int MAX_SUCCESSORS = 8;
  localparam int TASK_W         = $clog2(MAX_TASKS);
  localparam int SLOT_W         = $clog2(MAX_SUCCESSORS);
  localparam int SCNT_W         = $clog2(MAX_SUCCESSORS + 1);
  localparam int CNT_W          = $clog2(MAX_TASKS + 1);
  localparam int PEND_W         = 10;
  localparam int TAB_AW         = TASK_W + SLOT_W;

  localparam logic [PEND_W-1:0] PENDING_TOP = '1;

  typedef enum logic [1:0] {
    ACT_ADD    = 2'd0,
    ACT_RUN    = 2'd1,
    ACT_FINISH = 2'd2,
    ACT_CLEAR  = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    K_READY    = 3'd0,
    K_ACCEPTED = 3'd1,
    K_INVALID  = 3'd2,
    K_CYCLE    = 3'd3,
    K_DONE     = 3'd4,
    K_FULL     = 3'd5
  } kind_t;

  localparam logic [1:0] COL_WHITE = 2'd0;
  localparam logic [1:0] COL_GRAY  = 2'd1;
  localparam logic [1:0] COL_BLACK = 2'd2;

  typedef struct packed {
    logic [1:0]        action;
    logic [TASK_W-1:0] successor_task;
    logic [TASK_W-1:0] predecessor_task;
    logic [TASK_W-1:0] finished_task;
  } in_word_t;

  typedef struct packed {
    logic [2:0]        kind;
    logic [TASK_W-1:0] task_id;
    logic              last;
  } out_word_t;

endpackage

FILE: rtl/tds_out_reg.sv
// Output register of the task dependency scheduler: holds one result word
// until the receiver takes it. Depends on tds_pkg.
module tds_out_reg
  import tds_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push_valid,
  input  out_word_t push_word,
  output logic      push_ready,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_data
);

  logic      valid_r;
  out_word_t word_r;

  // Take a new word when empty or when the held one leaves this cycle
  assign push_ready = !valid_r || !out_stall;
  assign out_valid  = valid_r;
  assign out_data   = word_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (push_valid && push_ready) begin
      valid_r <= 1'b1;
    end else if (!out_stall) begin
      valid_r <= 1'b0;
    end
  end

  // Load payload
  always_ff @(posedge clk) begin
    if (push_valid && push_ready) begin
      word_r <= push_word;
    end
  end

endmodule

FILE: rtl/task_dependency_scheduler.sv
// Top level of the task dependency scheduler: sequencer, table memories and
// output register. Depends on tds_pkg and tds_out_reg.
//
// The block takes one command word at a time and holds in_stall high until
// its last result word has been handed to the output register. One sequencer
// drives every table through memories with one read and one write port and
// registered reads, so each table access waits for its read data. Task
// finished walks the finished task's successor list. Run graph does a
// depth-first cycle check from each start task, then a ready scan over
// all tasks. A stalled output holds the sequencer.
module task_dependency_scheduler
  import tds_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wr_en,
  input  logic [CNT_W-1:0]    cfg_wr_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  in_word_t            in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output out_word_t           out_data
);

  typedef enum logic [15:0] {
    S_IDLE   = 16'h0001,
    S_A_CHK  = 16'h0002,
    S_C_SEL  = 16'h0004,
    S_C_SEL2 = 16'h0008,
    S_C_TOP  = 16'h0010,
    S_C_NODE = 16'h0020,
    S_C_CNT  = 16'h0040,
    S_C_NEXT = 16'h0080,
    S_C_COL  = 16'h0100,
    S_SCAN   = 16'h0200,
    S_SCAN2  = 16'h0400,
    S_F_CNT  = 16'h0800,
    S_F_RD   = 16'h1000,
    S_F_S    = 16'h2000,
    S_F_P    = 16'h4000,
    S_FLUSH  = 16'h8000
  } state_t;

  // Control registers
  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   task_count_r;
  in_word_t           cur_r, cur_nxt;
  logic [CNT_W-1:0]   start_r, start_nxt;
  logic [CNT_W-1:0]   depth_r, depth_nxt;
  logic [CNT_W-1:0]   scan_r, scan_nxt;
  logic [CNT_W-1:0]   rem_r, rem_nxt;
  logic [TASK_W-1:0]  node_r, node_nxt;
  logic [TASK_W-1:0]  nxt_task_r, nxt_task_nxt;
  logic [SCNT_W-1:0]  pos_r, pos_nxt;
  logic [SCNT_W-1:0]  idx_r, idx_nxt;
  logic [SCNT_W-1:0]  cnt_r, cnt_nxt;
  logic               hold_v_r, hold_v_nxt;
  logic [2:0]         hold_kind_r, hold_kind_nxt;
  logic [TASK_W-1:0]  hold_id_r, hold_id_nxt;

  // Memories
  logic [TASK_W-1:0]  stab_mem [2**TAB_AW];
  logic [SCNT_W-1:0]  scnt_mem [MAX_TASKS];
  logic [MAX_TASKS-1:0] scnt_vld_r;
  logic [PEND_W-1:0]  pcnt_mem [MAX_TASKS];
  logic [MAX_TASKS-1:0] pcnt_vld_r;
  logic [1:0]         col_mem [MAX_TASKS];
  logic [MAX_TASKS-1:0] col_vld_r;
  logic [TASK_W-1:0]  stkt_mem [MAX_TASKS];
  logic [SCNT_W-1:0]  stkp_mem [MAX_TASKS];

  logic [TAB_AW-1:0]  stab_ra, stab_wa;
  logic [TASK_W-1:0]  stab_q, stab_wd;
  logic               stab_we;
  logic [TASK_W-1:0]  scnt_ra, scnt_wa;
  logic [SCNT_W-1:0]  scnt_q, scnt_wd;
  logic               scnt_vq, scnt_we;
  logic [TASK_W-1:0]  pcnt_ra, pcnt_wa;
  logic [PEND_W-1:0]  pcnt_q, pcnt_wd;
  logic               pcnt_vq, pcnt_we, pcnt_clr;
  logic [TASK_W-1:0]  col_ra, col_wa;
  logic [1:0]         col_q, col_wd;
  logic               col_vq, col_we, col_clr;
  logic [TASK_W-1:0]  stk_ra, stk_wa;
  logic [TASK_W-1:0]  stkt_q, stkt_wd;
  logic [SCNT_W-1:0]  stkp_q, stkp_wd;
  logic               stkt_we, stkp_we;

  logic [SCNT_W-1:0]  scnt_v;
  logic [PEND_W-1:0]  pcnt_v;
  logic [1:0]         col_v;
  logic [CNT_W-1:0]   n_eff;
  logic [CNT_W-1:0]   start_inc;
  logic [CNT_W-1:0]   top_idx;

  // Emission
  logic               emit_req, can_emit;
  logic [2:0]         emit_kind;
  logic [TASK_W-1:0]  emit_id;
  logic               push_valid, push_ready;
  out_word_t          push_word;

  assign scnt_v = scnt_vq ? scnt_q : '0;
  assign pcnt_v = pcnt_vq ? pcnt_q : '0;
  assign col_v  = col_vq ? col_q : COL_WHITE;

  // Clamp the task count to the supported range
  always_comb begin
    if (task_count_r == '0) begin
      n_eff = CNT_W'(1);
    end else if (task_count_r > CNT_W'(MAX_TASKS)) begin
      n_eff = CNT_W'(MAX_TASKS);
    end else begin
      n_eff = task_count_r;
    end
  end

  assign start_inc = start_r + CNT_W'(1);
  assign top_idx   = depth_r - CNT_W'(1);
  assign in_stall  = (state_r != S_IDLE);
  assign can_emit  = !hold_v_r || push_ready;

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    cur_nxt       = cur_r;
    start_nxt     = start_r;
    depth_nxt     = depth_r;
    scan_nxt      = scan_r;
    rem_nxt       = rem_r;
    node_nxt      = node_r;
    nxt_task_nxt  = nxt_task_r;
    pos_nxt       = pos_r;
    idx_nxt       = idx_r;
    cnt_nxt       = cnt_r;
    hold_v_nxt    = hold_v_r;
    hold_kind_nxt = hold_kind_r;
    hold_id_nxt   = hold_id_r;
    emit_req      = 1'b0;
    emit_kind     = K_READY;
    emit_id       = '0;
    push_valid    = 1'b0;
    push_word     = '{kind: hold_kind_r, task_id: hold_id_r, last: 1'b0};
    stab_ra = {cur_r.finished_task, idx_r[SLOT_W-1:0]};
    stab_we = 1'b0; stab_wa = {cur_r.predecessor_task, cnt_r[SLOT_W-1:0]};
    stab_wd = cur_r.successor_task;
    scnt_ra = in_data.predecessor_task;
    scnt_we = 1'b0; scnt_wa = cur_r.predecessor_task; scnt_wd = scnt_v + SCNT_W'(1);
    pcnt_ra = in_data.successor_task;
    pcnt_we = 1'b0; pcnt_wa = cur_r.successor_task; pcnt_wd = pcnt_v;
    pcnt_clr = 1'b0;
    col_ra = start_r[TASK_W-1:0];
    col_we = 1'b0; col_wa = start_r[TASK_W-1:0]; col_wd = COL_GRAY;
    col_clr = 1'b0;
    stk_ra = top_idx[TASK_W-1:0];
    stk_wa = top_idx[TASK_W-1:0];
    stkt_we = 1'b0; stkp_we = 1'b0;
    stkt_wd = start_r[TASK_W-1:0]; stkp_wd = '0;

    case (state_r)
      S_IDLE: begin
        if (in_data.action == ACT_FINISH) begin
          scnt_ra = in_data.finished_task;
        end
        if (in_valid) begin
          cur_nxt = in_data;
          case (in_data.action)
            ACT_ADD: begin
              if ({1'b0, in_data.successor_task} >= n_eff ||
                  {1'b0, in_data.predecessor_task} >= n_eff) begin
                hold_v_nxt = 1'b1; hold_kind_nxt = K_INVALID; hold_id_nxt = '0;
                state_nxt  = S_FLUSH;
              end else begin
                state_nxt = S_A_CHK;
              end
            end
            ACT_RUN: begin
              col_clr   = 1'b1;
              start_nxt = '0;
              state_nxt = S_C_SEL;
            end
            ACT_FINISH: begin
              if ({1'b0, in_data.finished_task} >= n_eff || rem_r == '0) begin
                hold_v_nxt = 1'b1; hold_kind_nxt = K_INVALID; hold_id_nxt = '0;
                state_nxt  = S_FLUSH;
              end else begin
                state_nxt = S_F_CNT;
              end
            end
            default: begin
              pcnt_clr  = 1'b1;
              rem_nxt   = '0;
              state_nxt = S_FLUSH;
            end
          endcase
        end
      end

      // Append to predecessor list and bump successor count, or report K_FULL
      S_A_CHK: begin
        if (scnt_v >= SCNT_W'(MAX_SUCCESSORS)) begin
          hold_v_nxt = 1'b1; hold_kind_nxt = K_FULL; hold_id_nxt = '0;
        end else begin
          cnt_nxt = scnt_v;
          stab_we = 1'b1;
          stab_wa = {cur_r.predecessor_task, scnt_v[SLOT_W-1:0]};
          scnt_we = 1'b1;
          pcnt_we = 1'b1;
          pcnt_wd = (pcnt_v == PENDING_TOP) ? pcnt_v : pcnt_v + PEND_W'(1);
        end
        state_nxt = S_FLUSH;
      end

      // Read the color of the next start task
      S_C_SEL: begin
        col_ra    = start_r[TASK_W-1:0];
        state_nxt = S_C_SEL2;
      end

      S_C_SEL2: begin
        if (col_v != COL_WHITE) begin
          if (start_inc == n_eff) begin
            scan_nxt = '0; rem_nxt = n_eff; state_nxt = S_SCAN;
          end else begin
            start_nxt = start_inc; state_nxt = S_C_SEL;
          end
        end else begin
          stk_wa    = '0;
          stkt_we   = 1'b1; stkt_wd = start_r[TASK_W-1:0];
          stkp_we   = 1'b1; stkp_wd = '0;
          col_we    = 1'b1; col_wa = start_r[TASK_W-1:0]; col_wd = COL_GRAY;
          depth_nxt = CNT_W'(1);
          state_nxt = S_C_TOP;
        end
      end

      // Fetch the walk stack top, or go on to the next start or the ready scan
      S_C_TOP: begin
        if (depth_r == '0) begin
          if (start_inc == n_eff) begin
            scan_nxt = '0; rem_nxt = n_eff; state_nxt = S_SCAN;
          end else begin
            start_nxt = start_inc; state_nxt = S_C_SEL;
          end
        end else begin
          stk_ra    = top_idx[TASK_W-1:0];
          state_nxt = S_C_NODE;
        end
      end

      S_C_NODE: begin
        node_nxt  = stkt_q;
        pos_nxt   = stkp_q;
        scnt_ra   = stkt_q;
        state_nxt = S_C_CNT;
      end

      // Step to the next list entry, or pop the finished node
      S_C_CNT: begin
        if (pos_r < scnt_v) begin
          stab_ra   = {node_r, pos_r[SLOT_W-1:0]};
          stk_wa    = top_idx[TASK_W-1:0];
          stkp_we   = 1'b1; stkp_wd = pos_r + SCNT_W'(1);
          state_nxt = S_C_NEXT;
        end else begin
          col_we    = 1'b1; col_wa = node_r; col_wd = COL_BLACK;
          depth_nxt = top_idx;
          state_nxt = S_C_TOP;
        end
      end

      S_C_NEXT: begin
        if ({1'b0, stab_q} >= n_eff) begin
          state_nxt = S_C_TOP;
        end else begin
          col_ra       = stab_q;
          nxt_task_nxt = stab_q;
          state_nxt    = S_C_COL;
        end
      end

      // Report a gray hit, push a white task
      S_C_COL: begin
        if (col_v == COL_GRAY) begin
          hold_v_nxt = 1'b1; hold_kind_nxt = K_CYCLE; hold_id_nxt = nxt_task_r;
          state_nxt  = S_FLUSH;
        end else begin
          if (col_v == COL_WHITE && depth_r < CNT_W'(MAX_TASKS)) begin
            col_we    = 1'b1; col_wa = nxt_task_r; col_wd = COL_GRAY;
            stk_wa    = depth_r[TASK_W-1:0];
            stkt_we   = 1'b1; stkt_wd = nxt_task_r;
            stkp_we   = 1'b1; stkp_wd = '0;
            depth_nxt = depth_r + CNT_W'(1);
          end
          state_nxt = S_C_TOP;
        end
      end

      // Emit every task with no pending dependency
      S_SCAN: begin
        pcnt_ra   = scan_r[TASK_W-1:0];
        state_nxt = S_SCAN2;
      end

      S_SCAN2: begin
        // keep the read address so the count holds while the output waits
        pcnt_ra   = scan_r[TASK_W-1:0];
        emit_req  = (pcnt_v == '0);
        emit_kind = K_READY;
        emit_id   = scan_r[TASK_W-1:0];
        if (!emit_req || can_emit) begin
          scan_nxt  = scan_r + CNT_W'(1);
          state_nxt = (scan_r + CNT_W'(1) == n_eff) ? S_FLUSH : S_SCAN;
        end
      end

      S_F_CNT: begin
        cnt_nxt   = scnt_v;
        idx_nxt   = '0;
        state_nxt = S_F_RD;
      end

      // Walk the finished task's successor list, then lower the remaining count
      S_F_RD: begin
        if (idx_r == cnt_r) begin
          emit_req  = (rem_r == CNT_W'(1));
          emit_kind = K_DONE;
          if (!emit_req || can_emit) begin
            rem_nxt   = rem_r - CNT_W'(1);
            state_nxt = S_FLUSH;
          end
        end else begin
          stab_ra   = {cur_r.finished_task, idx_r[SLOT_W-1:0]};
          state_nxt = S_F_S;
        end
      end

      S_F_S: begin
        if ({1'b0, stab_q} >= n_eff) begin
          idx_nxt   = idx_r + SCNT_W'(1);
          state_nxt = S_F_RD;
        end else begin
          pcnt_ra   = stab_q;
          node_nxt  = stab_q;
          state_nxt = S_F_P;
        end
      end

      S_F_P: begin
        // keep the read address so the count holds while the output waits
        pcnt_ra   = node_r;
        emit_req  = (pcnt_v == PEND_W'(1));
        emit_kind = K_READY;
        emit_id   = node_r;
        if (!emit_req || can_emit) begin
          if (pcnt_v != '0) begin
            pcnt_we = 1'b1; pcnt_wa = node_r; pcnt_wd = pcnt_v - PEND_W'(1);
          end
          idx_nxt   = idx_r + SCNT_W'(1);
          state_nxt = S_F_RD;
        end
      end

      // Hand over the held word, or K_ACCEPTED if none, as the final one
      S_FLUSH: begin
        push_valid = 1'b1;
        push_word  = hold_v_r ? '{kind: hold_kind_r, task_id: hold_id_r, last: 1'b1}
                              : '{kind: K_ACCEPTED, task_id: '0, last: 1'b1};
        if (push_ready) begin
          hold_v_nxt = 1'b0;
          state_nxt  = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // Release the held word and hold the new one
    if (emit_req && can_emit) begin
      push_valid    = hold_v_r;
      push_word     = '{kind: hold_kind_r, task_id: hold_id_r, last: 1'b0};
      hold_v_nxt    = 1'b1;
      hold_kind_nxt = emit_kind;
      hold_id_nxt   = emit_id;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      task_count_r <= CNT_W'(1);
      depth_r      <= '0;
      rem_r        <= '0;
      hold_v_r     <= 1'b0;
      scnt_vld_r   <= '0;
      pcnt_vld_r   <= '0;
      col_vld_r    <= '0;
    end else begin
      state_r  <= state_nxt;
      depth_r  <= depth_nxt;
      rem_r    <= rem_nxt;
      hold_v_r <= hold_v_nxt;
      if (cfg_wr_en) begin
        task_count_r <= cfg_wr_data;
      end
      if (scnt_we) begin
        scnt_vld_r[scnt_wa] <= 1'b1;
      end
      if (pcnt_clr) begin
        pcnt_vld_r <= '0;
      end else if (pcnt_we) begin
        pcnt_vld_r[pcnt_wa] <= 1'b1;
      end
      if (col_clr) begin
        col_vld_r <= '0;
      end else if (col_we) begin
        col_vld_r[col_wa] <= 1'b1;
      end
    end
  end

  // Working payload registers
  always_ff @(posedge clk) begin
    cur_r       <= cur_nxt;
    start_r     <= start_nxt;
    scan_r      <= scan_nxt;
    node_r      <= node_nxt;
    nxt_task_r  <= nxt_task_nxt;
    pos_r       <= pos_nxt;
    idx_r       <= idx_nxt;
    cnt_r       <= cnt_nxt;
    hold_kind_r <= hold_kind_nxt;
    hold_id_r   <= hold_id_nxt;
  end

  // Table memories with registered reads
  always_ff @(posedge clk) begin
    stab_q  <= stab_mem[stab_ra];
    scnt_q  <= scnt_mem[scnt_ra];
    scnt_vq <= scnt_vld_r[scnt_ra];
    pcnt_q  <= pcnt_mem[pcnt_ra];
    pcnt_vq <= pcnt_vld_r[pcnt_ra];
    col_q   <= col_mem[col_ra];
    col_vq  <= col_vld_r[col_ra];
    stkt_q  <= stkt_mem[stk_ra];
    stkp_q  <= stkp_mem[stk_ra];
    if (stab_we) begin
      stab_mem[stab_wa] <= stab_wd;
    end
    if (scnt_we) begin
      scnt_mem[scnt_wa] <= scnt_wd;
    end
    if (pcnt_we) begin
      pcnt_mem[pcnt_wa] <= pcnt_wd;
    end
    if (col_we) begin
      col_mem[col_wa] <= col_wd;
    end
    if (stkt_we) begin
      stkt_mem[stk_wa] <= stkt_wd;
    end
    if (stkp_we) begin
      stkp_mem[stk_wa] <= stkp_wd;
    end
  end

  tds_out_reg u_out_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_word  (push_word),
    .push_ready (push_ready),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule
